[design/ectd_pkg.sv]
// ----------------------------------------------------------------------------
// ectd_pkg: shared definitions for the editable clock
// Event codes, selection codes, register indexes, display characters,
// state bundles and the small decimal helpers used by the display logic.
// ----------------------------------------------------------------------------
package ectd_pkg;

  // Event codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_DIGIT  = 2'd1,
    FUNC_COMMIT = 2'd2,
    FUNC_MODE   = 2'd3
  } func_e;

  // Selection codes: commit target or display mode.
  localparam logic [1:0] SEL_NORMAL  = 2'd0;
  localparam logic [1:0] SEL_HOURS   = 2'd1;
  localparam logic [1:0] SEL_MINUTES = 2'd2;
  localparam logic [1:0] SEL_SECONDS = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_STEP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 8'd1;

  localparam logic [7:0] TICKS_PER_STEP_RST   = 8'd10;
  localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd100;

  // Time limits.
  localparam logic [4:0] HOURS_MAX   = 5'd23;
  localparam logic [5:0] MINUTES_MAX = 6'd59;
  localparam logic [5:0] SECONDS_MAX = 6'd59;
  localparam logic [7:0] ENTRY_SAT   = 8'd255;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;

  // ASCII characters used on the display.
  localparam logic [6:0] CH_SPACE  = 7'd32;
  localparam logic [6:0] CH_ZERO   = 7'd48;
  localparam logic [6:0] CH_COLON  = 7'd58;
  localparam logic [6:0] CH_CURSOR = 7'd95;

  typedef logic [6:0] char_t;
  typedef char_t [7:0] chars_t;

  // One accepted event word.
  typedef struct packed {
    func_e      func;
    logic [3:0] digit;
    logic       first_digit;
    logic [1:0] selection;
  } event_t;

  // State seen by the display formatter.
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] entry;
    logic       entry_valid;
    logic       cursor;
    logic [1:0] mode;
  } disp_state_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Two low decimal digits of an 8-bit value, by reciprocal multiplication.
  // x * 205 >> 11 equals x / 10 for every 8-bit x.
  function automatic digits_t dec2(input logic [7:0] v);
    logic [15:0] p1;
    logic [4:0]  q1;
    logic [7:0]  r1;
    logic [12:0] p2;
    logic [1:0]  q2;
    logic [4:0]  r2;
    digits_t     d;
    p1 = {8'd0, v} * 16'd205;
    q1 = p1[15:11];
    r1 = v - ({3'd0, q1} * 8'd10);
    p2 = {8'd0, q1} * 13'd205;
    q2 = p2[12:11];
    r2 = q1 - ({3'd0, q2} * 5'd10);
    d.tens = r2[3:0];
    d.ones = r1[3:0];
    return d;
  endfunction

  function automatic char_t to_ascii(input logic [3:0] d);
    return CH_ZERO + {3'd0, d};
  endfunction

endpackage

[design/ectd_intf.sv]
// ----------------------------------------------------------------------------
// ectd_intf: channel interfaces of the editable clock
// Event input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------

// Event channel: one word per tick, digit, commit or mode change.
interface ectd_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] digit;
  logic       first_digit;
  logic [1:0] selection;

  modport source (output valid, func, digit, first_digit, selection, input ready);
  modport sink   (input valid, func, digit, first_digit, selection, output ready);
endinterface

// Result channel: one word per tick event.
interface ectd_res_if;
  logic       valid;
  logic       ready;
  logic       step_pulse;
  logic       second_pulse;
  logic [6:0] char0;
  logic [6:0] char1;
  logic [6:0] char2;
  logic [6:0] char3;
  logic [6:0] char4;
  logic [6:0] char5;
  logic [6:0] char6;
  logic [6:0] char7;

  modport source (output valid, step_pulse, second_pulse, char0, char1, char2, char3,
                  char4, char5, char6, char7, input ready);
  modport sink   (input valid, step_pulse, second_pulse, char0, char1, char2, char3,
                  char4, char5, char6, char7, output ready);
endinterface

// Configuration write channel.
interface ectd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/ectd_divider.sv]
// ----------------------------------------------------------------------------
// ectd_divider: tick divider
// Counts base ticks and flags the tick on which the count reaches the limit.
// ----------------------------------------------------------------------------
module ectd_divider (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  logic [7:0] limit_i,
  output logic       wrap_o
);

  logic [7:0] count_q;
  logic [7:0] count_d;
  logic [7:0] count_inc;

  // The count wraps once the incremented value reaches or passes the limit.
  assign count_inc = count_q + 8'd1;
  assign wrap_o    = (count_inc >= limit_i);

  always_comb begin
    count_d = count_q;
    if (tick_i) begin
      count_d = wrap_o ? 8'd0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 8'd0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

[design/ectd_display.sv]
// ----------------------------------------------------------------------------
// ectd_display: hh:mm:ss display formatter
// Forms the eight display characters from the time and the edit state.
// ----------------------------------------------------------------------------
module ectd_display (
  input  ectd_pkg::disp_state_t st_i,
  output ectd_pkg::chars_t      chars_o
);

  ectd_pkg::digits_t hrs_dig;
  ectd_pkg::digits_t min_dig;
  ectd_pkg::digits_t sec_dig;
  ectd_pkg::digits_t ent_dig;
  ectd_pkg::char_t   cur_ch;
  ectd_pkg::char_t   edit_hi;
  ectd_pkg::char_t   edit_lo;

  assign hrs_dig = ectd_pkg::dec2({3'd0, st_i.hours});
  assign min_dig = ectd_pkg::dec2({2'd0, st_i.minutes});
  assign sec_dig = ectd_pkg::dec2({2'd0, st_i.seconds});
  assign ent_dig = ectd_pkg::dec2(st_i.entry);
  assign cur_ch  = st_i.cursor ? ectd_pkg::CH_CURSOR : ectd_pkg::CH_SPACE;

  // Edited field: cursor alone, cursor and one digit, or the entry's two low decimal digits.
  always_comb begin
    if (!st_i.entry_valid) begin
      edit_hi = ectd_pkg::CH_SPACE;
      edit_lo = cur_ch;
    end else if (st_i.entry < 8'd10) begin
      edit_hi = cur_ch;
      edit_lo = ectd_pkg::to_ascii(st_i.entry[3:0]);
    end else begin
      edit_hi = ectd_pkg::to_ascii(ent_dig.tens);
      edit_lo = ectd_pkg::to_ascii(ent_dig.ones);
    end
  end

  // Plain time, then the edited field laid over it.
  always_comb begin
    chars_o[0] = ectd_pkg::to_ascii(hrs_dig.tens);
    chars_o[1] = ectd_pkg::to_ascii(hrs_dig.ones);
    chars_o[2] = ectd_pkg::CH_COLON;
    chars_o[3] = ectd_pkg::to_ascii(min_dig.tens);
    chars_o[4] = ectd_pkg::to_ascii(min_dig.ones);
    chars_o[5] = ectd_pkg::CH_COLON;
    chars_o[6] = ectd_pkg::to_ascii(sec_dig.tens);
    chars_o[7] = ectd_pkg::to_ascii(sec_dig.ones);
    case (st_i.mode)
      ectd_pkg::SEL_HOURS: begin
        chars_o[0] = edit_hi;
        chars_o[1] = edit_lo;
      end
      ectd_pkg::SEL_MINUTES: begin
        chars_o[3] = edit_hi;
        chars_o[4] = edit_lo;
      end
      ectd_pkg::SEL_SECONDS: begin
        chars_o[6] = edit_hi;
        chars_o[7] = edit_lo;
      end
      default: begin
      end
    endcase
  end

endmodule

[design/editable_clock_with_tick_divider_unit.sv]
// ----------------------------------------------------------------------------
// editable_clock_with_tick_divider_unit: editable hh:mm:ss clock
// Tick dividers, time counters, entry editing and display output.
// ----------------------------------------------------------------------------
// Usage:
//   evt_i carries event words: base tick, digit entry, field commit or
//   display-mode change. Only a tick word produces a result word on res_o,
//   holding the step and second pulses and the eight display characters
//   (all zero when no second elapsed). cfg_i writes the two divider limits
//   and is always ready; write it only while the block is idle.
//   An accepted word lands in an input register; when it leaves that
//   register its state update is applied and, for a tick, the result
//   word is loaded into the output register. A tick word leaves the
//   input register only while the output register is free or read.
//   One word per cycle is sustained while the receiver takes results:
//   every event updates the state through short logic from the input
//   register to the state and output registers.
//   When the receiver stalls, the output register holds its word and one
//   more word waits in the input register; a tick word then stalls evt_i,
//   while other event words keep flowing.
//   Reset clears the time, the dividers, the entry and the cursor, selects
//   normal mode and loads limits of 10 and 100 ticks.
// ----------------------------------------------------------------------------
module editable_clock_with_tick_divider_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ectd_evt_if.sink   evt_i,
  ectd_res_if.source res_o,
  ectd_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [7:0] tps_step_q;
  logic [7:0] tps_sec_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_step_q <= ectd_pkg::TICKS_PER_STEP_RST;
      tps_sec_q  <= ectd_pkg::TICKS_PER_SECOND_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == ectd_pkg::CFG_TICKS_PER_STEP) begin
        tps_step_q <= cfg_i.data;
      end
      if (cfg_i.index == ectd_pkg::CFG_TICKS_PER_SECOND) begin
        tps_sec_q <= cfg_i.data;
      end
    end
  end

  // Input register.
  logic                stg_valid_q;
  ectd_pkg::event_t    stg_q;
  logic                stg_fire;
  logic                stg_tick;
  logic                res_valid_q;
  logic                evt_take;

  assign stg_tick = (stg_q.func == ectd_pkg::FUNC_TICK);
  assign stg_fire = stg_valid_q && (!stg_tick || !res_valid_q || res_o.ready);
  assign evt_i.ready = !stg_valid_q || stg_fire;
  assign evt_take = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      stg_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_take) begin
      stg_q.func        <= ectd_pkg::func_e'(evt_i.func);
      stg_q.digit       <= evt_i.digit;
      stg_q.first_digit <= evt_i.first_digit;
      stg_q.selection   <= evt_i.selection;
    end
  end

  // Tick dividers.
  logic tick_fire;
  logic step_wrap;
  logic sec_wrap;

  assign tick_fire = stg_fire && stg_tick;

  ectd_divider u_step_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_fire),
    .limit_i (tps_step_q),
    .wrap_o  (step_wrap)
  );

  ectd_divider u_sec_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_fire),
    .limit_i (tps_sec_q),
    .wrap_o  (sec_wrap)
  );

  // Clock and edit state.
  logic [4:0] hours_q,   hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic [7:0] entry_q,   entry_d;
  logic       entry_vld_q, entry_vld_d;
  logic       cursor_q,  cursor_d;
  logic [1:0] mode_q,    mode_d;
  logic [11:0] entry_app;

  // Display formed with the toggled cursor and the time before this second.
  ectd_pkg::disp_state_t disp_st;
  ectd_pkg::chars_t      disp_chars;

  assign disp_st.hours       = hours_q;
  assign disp_st.minutes     = minutes_q;
  assign disp_st.seconds     = seconds_q;
  assign disp_st.entry       = entry_q;
  assign disp_st.entry_valid = entry_vld_q;
  assign disp_st.cursor      = !cursor_q;
  assign disp_st.mode        = mode_q;

  ectd_display u_display (
    .st_i    (disp_st),
    .chars_o (disp_chars)
  );

  assign entry_app = ({4'd0, entry_q} * 12'd10) + {8'd0, stg_q.digit};

  // State update for the event in the input register.
  always_comb begin
    hours_d     = hours_q;
    minutes_d   = minutes_q;
    seconds_d   = seconds_q;
    entry_d     = entry_q;
    entry_vld_d = entry_vld_q;
    cursor_d    = cursor_q;
    mode_d      = mode_q;
    if (stg_fire) begin
      case (stg_q.func)
        ectd_pkg::FUNC_TICK: begin
          if (sec_wrap) begin
            cursor_d = !cursor_q;
            if (mode_q == ectd_pkg::SEL_NORMAL) begin
              entry_d     = 8'd0;
              entry_vld_d = 1'b0;
            end
            if (seconds_q >= ectd_pkg::SECONDS_MAX) begin
              seconds_d = 6'd0;
              if (minutes_q >= ectd_pkg::MINUTES_MAX) begin
                minutes_d = 6'd0;
                hours_d   = (hours_q >= ectd_pkg::HOURS_MAX) ? 5'd0 : hours_q + 5'd1;
              end else begin
                minutes_d = minutes_q + 6'd1;
              end
            end else begin
              seconds_d = seconds_q + 6'd1;
            end
          end
        end
        ectd_pkg::FUNC_DIGIT: begin
          // Digits above nine are dropped; appending saturates the entry.
          if (stg_q.digit <= ectd_pkg::DIGIT_MAX) begin
            if (stg_q.first_digit || !entry_vld_q) begin
              entry_d = {4'd0, stg_q.digit};
            end else begin
              entry_d = (entry_app > {4'd0, ectd_pkg::ENTRY_SAT}) ?
                        ectd_pkg::ENTRY_SAT : entry_app[7:0];
            end
            entry_vld_d = 1'b1;
          end
        end
        ectd_pkg::FUNC_COMMIT: begin
          // Only an in-range entry is stored; the entry itself is kept.
          if (entry_vld_q) begin
            case (stg_q.selection)
              ectd_pkg::SEL_HOURS: begin
                if (entry_q <= {3'd0, ectd_pkg::HOURS_MAX}) hours_d = entry_q[4:0];
              end
              ectd_pkg::SEL_MINUTES: begin
                if (entry_q <= {2'd0, ectd_pkg::MINUTES_MAX}) minutes_d = entry_q[5:0];
              end
              ectd_pkg::SEL_SECONDS: begin
                if (entry_q <= {2'd0, ectd_pkg::SECONDS_MAX}) seconds_d = entry_q[5:0];
              end
              default: begin
              end
            endcase
          end
        end
        ectd_pkg::FUNC_MODE: begin
          mode_d = stg_q.selection;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hours_q     <= 5'd0;
      minutes_q   <= 6'd0;
      seconds_q   <= 6'd0;
      entry_q     <= 8'd0;
      entry_vld_q <= 1'b0;
      cursor_q    <= 1'b0;
      mode_q      <= ectd_pkg::SEL_NORMAL;
    end else begin
      hours_q     <= hours_d;
      minutes_q   <= minutes_d;
      seconds_q   <= seconds_d;
      entry_q     <= entry_d;
      entry_vld_q <= entry_vld_d;
      cursor_q    <= cursor_d;
      mode_q      <= mode_d;
    end
  end

  // Output register.
  logic             res_step_q;
  logic             res_sec_q;
  ectd_pkg::chars_t res_chars_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (tick_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      res_step_q  <= step_wrap;
      res_sec_q   <= sec_wrap;
      res_chars_q <= sec_wrap ? disp_chars : '0;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.step_pulse   = res_step_q;
  assign res_o.second_pulse = res_sec_q;
  assign res_o.char0        = res_chars_q[0];
  assign res_o.char1        = res_chars_q[1];
  assign res_o.char2        = res_chars_q[2];
  assign res_o.char3        = res_chars_q[3];
  assign res_o.char4        = res_chars_q[4];
  assign res_o.char5        = res_chars_q[5];
  assign res_o.char6        = res_chars_q[6];
  assign res_o.char7        = res_chars_q[7];

`ifndef ASSERT_OFF
  // The time never leaves its legal range.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hours_q <= ectd_pkg::HOURS_MAX && minutes_q <= ectd_pkg::MINUTES_MAX &&
    seconds_q <= ectd_pkg::SECONDS_MAX)
    else $error("time value out of range");

  // A new result word follows a tick leaving the input register.
  a_res_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(tick_fire))
    else $error("result word without a tick");

  // A second result carries both colons; otherwise the display is blank.
  a_colons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_sec_q |->
      res_chars_q[2] == ectd_pkg::CH_COLON && res_chars_q[5] == ectd_pkg::CH_COLON)
    else $error("display colons missing");

  a_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_sec_q |-> res_chars_q == '0)
    else $error("display not blank without a second pulse");
`endif

endmodule
